### rtl/core/tgc_pkg.sv
// Package for the touch gesture classifier: payload structs, command and
// class codes, state struct and the magnitude helper. No dependencies.
package tgc_pkg;

  localparam int SWIPE_DELTA_DEFAULT = 10;

  localparam logic [2:0] CMD_SWIPE_BEGIN  = 3'd0;
  localparam logic [2:0] CMD_SWIPE_UPDATE = 3'd1;
  localparam logic [2:0] CMD_SWIPE_END    = 3'd2;
  localparam logic [2:0] CMD_PINCH_BEGIN  = 3'd3;
  localparam logic [2:0] CMD_PINCH_UPDATE = 3'd4;
  localparam logic [2:0] CMD_PINCH_END    = 3'd5;

  localparam logic [2:0] CLS_UNKNOWN   = 3'd0;
  localparam logic [2:0] CLS_UP        = 3'd1;
  localparam logic [2:0] CLS_DOWN      = 3'd2;
  localparam logic [2:0] CLS_LEFT      = 3'd3;
  localparam logic [2:0] CLS_RIGHT     = 3'd4;
  localparam logic [2:0] CLS_PINCH_IN  = 3'd5;
  localparam logic [2:0] CLS_PINCH_OUT = 3'd6;

  localparam logic KIND_SWIPE = 1'b0;
  localparam logic KIND_PINCH = 1'b1;

  localparam logic [15:0] SCALE_ONE    = 16'd256;
  localparam logic [14:0] THRESH_RESET = 15'(16 * SWIPE_DELTA_DEFAULT);

  typedef struct packed {
    logic [2:0]         command;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic [15:0]        scale;
    logic [3:0]         fingers;
    logic               cancelled;
  } tgc_in_t;

  typedef struct packed {
    logic       gesture_kind;
    logic [2:0] direction;
    logic [3:0] reported_fingers;
  } tgc_out_t;

  typedef struct packed {
    logic signed [15:0] largest_x;
    logic signed [15:0] largest_y;
    logic [2:0]         last_class;
  } tgc_state_t;

  // |v| of a 16-bit signed value; 17 bits so that -32768 fits
  function automatic logic [16:0] tgc_mag(input logic signed [15:0] v);
    logic [16:0] ext;
    ext = {v[15], v};
    return v[15] ? (~ext + 17'd1) : ext;
  endfunction

endpackage

### rtl/core/touch_gesture_classifier.sv
// Top level of the touch gesture classifier: input register, state, result
// register. Depends on tgc_pkg and tgc_classify.
//
//   channel  ports                          payload
//   input    in_valid, in_stall, in_item    tgc_in_t
//   result   out_valid, out_stall, out_item tgc_out_t
//   config   cfg_we, cfg_wdata              swipe_threshold, 15 bits
//
// One event per cycle while in_stall is low; a result passes the input register, then the result register.
// The state update is combinational between the input and result registers.
// Reset clears the maxima and the class, and sets the threshold to 10.0.
// A stalled result holds back only an end event that makes a result; others pass.
module touch_gesture_classifier (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tgc_pkg::tgc_in_t   in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output tgc_pkg::tgc_out_t  out_item,
  input  logic               cfg_we,
  input  logic [14:0]        cfg_wdata
);
  import tgc_pkg::*;

  logic        p1_valid_r;
  tgc_in_t     p1_item_r;
  tgc_state_t  st_r, st_nxt;
  logic [14:0] thresh_r;
  logic        out_valid_r;
  tgc_out_t    out_item_r, result;
  logic        emit, out_free, p1_go;

  tgc_classify u_classify (
    .item      (p1_item_r),
    .cur       (st_r),
    .threshold (thresh_r),
    .nxt       (st_nxt),
    .emit      (emit),
    .result    (result)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign p1_go    = p1_valid_r && (!emit || out_free);
  assign in_stall = p1_valid_r && !p1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
    end else if (cfg_we) begin
      thresh_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      p1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) p1_item_r <= in_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{largest_x: '0, largest_y: '0, last_class: CLS_UNKNOWN};
    end else if (p1_go) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= p1_go && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && p1_go && emit) out_item_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> p1_valid_r && emit && out_valid_r)
    else $error("input stalled without a blocked end event");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    p1_go && ((p1_item_r.command == CMD_SWIPE_END) || (p1_item_r.command == CMD_PINCH_END))
    |=> st_r.largest_x == 16'sd0 && st_r.largest_y == 16'sd0)
    else $error("end transfer did not clear the maxima");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(p1_valid_r) && $past(emit))
    else $error("result appeared without an end event");

  a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_item_r))
    else $error("stalled result dropped or changed");

endmodule

### rtl/core/tgc_classify.sv
// Combinational next-state and result logic for one gesture event.
// Depends on tgc_pkg.
module tgc_classify (
  input  tgc_pkg::tgc_in_t    item,
  input  tgc_pkg::tgc_state_t cur,
  input  logic [14:0]         threshold,
  output tgc_pkg::tgc_state_t nxt,
  output logic                emit,
  output tgc_pkg::tgc_out_t   result
);
  import tgc_pkg::*;

  logic signed [15:0] new_x, new_y;
  logic [16:0]        mag_x, mag_y, th_ext;
  logic [2:0]         swipe_cls, pinch_cls;
  logic               is_end;

  assign th_ext = {2'b00, threshold};

  always_comb begin
    new_x = (tgc_mag(cur.largest_x) < tgc_mag(item.delta_x)) ? item.delta_x : cur.largest_x;
    new_y = (tgc_mag(cur.largest_y) < tgc_mag(item.delta_y)) ? item.delta_y : cur.largest_y;
    mag_x = tgc_mag(new_x);
    mag_y = tgc_mag(new_y);
    swipe_cls = CLS_UNKNOWN;
    if (mag_y > mag_x) begin
      if (mag_y > th_ext) swipe_cls = new_y[15] ? CLS_UP : CLS_DOWN;
    end else if (mag_x > mag_y) begin
      if (mag_x > th_ext) swipe_cls = new_x[15] ? CLS_LEFT : CLS_RIGHT;
    end
  end

  always_comb begin
    if (item.scale > SCALE_ONE)      pinch_cls = CLS_PINCH_OUT;
    else if (item.scale < SCALE_ONE) pinch_cls = CLS_PINCH_IN;
    else                             pinch_cls = CLS_UNKNOWN;
  end

  assign is_end = (item.command == CMD_SWIPE_END) || (item.command == CMD_PINCH_END);

  always_comb begin
    nxt = cur;
    unique case (item.command)
      CMD_SWIPE_UPDATE: begin
        nxt.largest_x  = new_x;
        nxt.largest_y  = new_y;
        nxt.last_class = swipe_cls;
      end
      CMD_PINCH_UPDATE: begin
        nxt.last_class = pinch_cls;
      end
      CMD_SWIPE_END, CMD_PINCH_END: begin
        nxt.largest_x = '0;
        nxt.largest_y = '0;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

  assign emit                    = is_end && !item.cancelled;
  assign result.gesture_kind     = (item.command == CMD_PINCH_END) ? KIND_PINCH : KIND_SWIPE;
  assign result.direction        = cur.last_class;
  assign result.reported_fingers = item.fingers;

endmodule
